/* src/rfd_pkg.sv */
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants for the RPC frame deframer
// Word layouts of the byte and result channels, result kinds, error codes,
// deframer phases and the header magic.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

	// header geometry
	localparam int unsigned HdrLen     = 12;
	localparam int unsigned MagicLen   = 4;
	localparam int unsigned SizeEnd    = 8;
	localparam int unsigned HdrIdxW    = 4;

	localparam logic [31:0] MaxBodyReset = 32'h0400_0000;

	// four-byte magic, in stream order
	localparam logic [7:0] MAGIC [MagicLen] = '{8'h46, 8'h52, 8'h50, 8'h43};

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_META   = 2'd1,
		KIND_PAY    = 2'd2,
		KIND_ERROR  = 2'd3
	} rfd_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_MAGIC     = 2'd1,
		ERR_TOO_BIG   = 2'd2,
		ERR_META_BODY = 2'd3
	} rfd_err_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_HALT   = 2'd2
	} rfd_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_over;
	} rfd_in_t;

	typedef struct packed {
		rfd_kind_t   kind;
		logic [7:0]  out_byte;
		logic [31:0] body_length;
		logic [31:0] meta_length;
		rfd_err_t    err_code;
		logic        last_of_frame;
	} rfd_out_t;

endpackage

`default_nettype wire

/* src/rpc_frame_deframer.sv */
// ----------------------------------------------------------------------------
// rpc_frame_deframer: streaming deframer for a 12-byte-header RPC framing
// Checks the magic byte by byte, decodes body and metadata sizes, reports a
// header word and then forwards body bytes tagged metadata or payload.
// ----------------------------------------------------------------------------
//
//  channel | signals                              | word
//  --------+--------------------------------------+---------------------------
//  byte    | byte_valid, byte_stall, byte_word    | rfd_in_t, one stream byte
//  result  | res_valid, res_stall, res_word       | rfd_out_t, zero/one a byte
//  config  | cfg_we, cfg_wdata                    | max_body_size
//
//  One byte per clock while byte_stall is low: the decode, size compares and
//  counters sit between the frame state and a single result register, so a
//  byte's result, if any, is valid in the cycle after it is accepted. byte_stall
//  is high only while a result is held in the result register and res_stall is
//  high; the result register refills in the cycle it drains. arst_n clears the
//  phase, counters and result valid; max_body_size resets to 64 MiB.
//
`default_nettype none

module rpc_frame_deframer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            byte_valid,
	output logic                 byte_stall,
	input  wire rfd_pkg::rfd_in_t byte_word,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output rfd_pkg::rfd_out_t    res_word,
	input  wire logic            cfg_we,
	input  wire logic [31:0]     cfg_wdata
);
	import rfd_pkg::*;

	// frame state
	rfd_phase_t           phase_q, phase_d;
	logic [HdrIdxW-1:0]   hdr_idx_q, hdr_idx_d;
	logic [31:0]          body_tot_q, body_tot_d;
	logic [31:0]          meta_tot_q, meta_tot_d;
	logic [31:0]          bytes_left_q, bytes_left_d;
	logic [31:0]          meta_left_q, meta_left_d;
	logic [31:0]          max_body_q;

	// result register
	logic                 res_valid_q;
	rfd_out_t             res_word_q;

	logic                 accept;
	logic                 has_res;
	rfd_out_t             res_d;

	// effective state after a start-over
	rfd_phase_t           ph_e;
	logic [HdrIdxW-1:0]   idx_e;
	logic [31:0]          body_e;
	logic [31:0]          meta_e;
	logic [31:0]          body_n;
	logic [31:0]          meta_n;

	assign byte_stall = res_valid_q && res_stall;
	assign accept     = byte_valid && !byte_stall;
	assign res_valid  = res_valid_q;
	assign res_word   = res_word_q;

	// next state and result
	always_comb begin
		ph_e   = byte_word.start_over ? PH_HEADER : phase_q;
		idx_e  = byte_word.start_over ? '0 : hdr_idx_q;
		body_e = byte_word.start_over ? '0 : body_tot_q;
		meta_e = byte_word.start_over ? '0 : meta_tot_q;
		body_n = body_e;
		meta_n = meta_e;

		phase_d      = ph_e;
		hdr_idx_d    = idx_e;
		body_tot_d   = body_e;
		meta_tot_d   = meta_e;
		bytes_left_d = byte_word.start_over ? '0 : bytes_left_q;
		meta_left_d  = byte_word.start_over ? '0 : meta_left_q;

		has_res             = 1'b0;
		res_d.kind          = KIND_HEADER;
		res_d.out_byte      = '0;
		res_d.body_length   = '0;
		res_d.meta_length   = '0;
		res_d.err_code      = ERR_NONE;
		res_d.last_of_frame = 1'b0;

		unique case (ph_e)
			PH_HEADER: begin
				if (idx_e < HdrIdxW'(MagicLen)) begin
					// magic check
					if (byte_word.data_byte != MAGIC[idx_e[1:0]]) begin
						phase_d             = PH_HALT;
						hdr_idx_d           = '0;
						has_res             = 1'b1;
						res_d.kind          = KIND_ERROR;
						res_d.err_code      = ERR_MAGIC;
						res_d.last_of_frame = 1'b1;
					end else begin
						hdr_idx_d = idx_e + HdrIdxW'(1);
					end
				end else begin
					if (idx_e < HdrIdxW'(SizeEnd)) begin
						body_n = {body_e[23:0], byte_word.data_byte};
					end else begin
						meta_n = {meta_e[23:0], byte_word.data_byte};
					end
					body_tot_d = body_n;
					meta_tot_d = meta_n;
					hdr_idx_d  = idx_e + HdrIdxW'(1);
					// size check on the last header byte
					if (idx_e == HdrIdxW'(HdrLen - 1)) begin
						hdr_idx_d           = '0;
						has_res             = 1'b1;
						res_d.body_length   = body_n;
						res_d.meta_length   = meta_n;
						if (body_n > max_body_q) begin
							phase_d             = PH_HALT;
							res_d.kind          = KIND_ERROR;
							res_d.err_code      = ERR_TOO_BIG;
							res_d.last_of_frame = 1'b1;
						end else if (meta_n > body_n) begin
							phase_d             = PH_HALT;
							res_d.kind          = KIND_ERROR;
							res_d.err_code      = ERR_META_BODY;
							res_d.last_of_frame = 1'b1;
						end else begin
							bytes_left_d        = body_n;
							meta_left_d         = meta_n;
							phase_d             = (body_n == '0) ? PH_HEADER : PH_BODY;
							res_d.last_of_frame = (body_n == '0);
						end
					end
				end
			end
			PH_BODY: begin
				// forward one body byte
				has_res             = 1'b1;
				res_d.kind          = (meta_left_q != '0) ? KIND_META : KIND_PAY;
				res_d.out_byte      = byte_word.data_byte;
				res_d.last_of_frame = (bytes_left_q <= 32'd1);
				meta_left_d         = (meta_left_q != '0) ? meta_left_q - 32'd1 : '0;
				bytes_left_d        = (bytes_left_q != '0) ? bytes_left_q - 32'd1 : '0;
				if (bytes_left_q <= 32'd1) begin
					phase_d   = PH_HEADER;
					hdr_idx_d = '0;
				end
			end
			default: begin
				// halted: drop the byte
				has_res = 1'b0;
			end
		endcase
	end

	// frame state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_idx_q    <= '0;
			body_tot_q   <= '0;
			meta_tot_q   <= '0;
			bytes_left_q <= '0;
			meta_left_q  <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			hdr_idx_q    <= hdr_idx_d;
			body_tot_q   <= body_tot_d;
			meta_tot_q   <= meta_tot_d;
			bytes_left_q <= bytes_left_d;
			meta_left_q  <= meta_left_d;
		end
	end

	// max body size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MaxBodyReset;
		end else if (cfg_we) begin
			max_body_q <= cfg_wdata;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= has_res;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept && has_res) begin
			res_word_q <= res_d;
		end
	end

endmodule

`default_nettype wire

/* src/rfd_checker.sv */
// ----------------------------------------------------------------------------
// rfd_checker: port-level checks for the RPC frame deframer
// Watches the byte stall and the result ports; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              byte_stall,
	input wire logic              res_valid,
	input wire logic              res_stall,
	input wire rfd_pkg::rfd_out_t res_word
);
	import rfd_pkg::*;

	// a held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// input backpressure only comes from a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> res_valid && res_stall)
		else $error("byte stall without a held result");

	// errors close the frame and carry a code
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.kind == KIND_ERROR |->
			res_word.last_of_frame && res_word.err_code != ERR_NONE)
		else $error("error word without code or last mark");

	// non-error words carry no code
	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.kind != KIND_ERROR |-> res_word.err_code == ERR_NONE)
		else $error("error code on a non-error word");

	// body words carry no lengths
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.kind == KIND_META || res_word.kind == KIND_PAY) |->
			res_word.body_length == '0 && res_word.meta_length == '0)
		else $error("lengths on a body word");

endmodule

bind rpc_frame_deframer rfd_checker u_rfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_stall (byte_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_word   (res_word)
);

`default_nettype wire

/* test/tb_rpc_frame_deframer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rpc_frame_deframer: self-checking bench for the RPC frame deframer
// Streams good, broken and abandoned frames through the byte channel under
// random gaps and result stalls, predicts every result word from a model of
// the frame state kept in a small scoreboard, and compares field by field.
// ----------------------------------------------------------------------------

module tb_rpc_frame_deframer;
	import rfd_pkg::*;

	// header magic, first stream byte in the top octet
	localparam logic [31:0] HDR_MAGIC = 32'h4652_5043;

	localparam int unsigned QUIET_LIMIT = 2000;

	class deframe_scoreboard;
		rfd_out_t    pending_words[$];
		logic [31:0] max_body;
		rfd_phase_t  phase;
		int unsigned hdr_idx;
		logic [31:0] body_total;
		logic [31:0] meta_total;
		logic [31:0] bytes_left;
		int unsigned errors;

		function new();
			max_body   = 32'h0400_0000;
			phase      = PH_HEADER;
			hdr_idx    = 0;
			body_total = '0;
			meta_total = '0;
			bytes_left = '0;
			errors     = 0;
		endfunction

		// true when the next byte would not be header byte 0
		function bit mid_frame();
			return phase != PH_HEADER || hdr_idx != 0;
		endfunction

		// advance the frame state by one accepted byte word, queue its result if any
		function void note_byte(rfd_in_t w);
			rfd_out_t    r;
			logic [31:0] pos;
			r = '0;
			if (w.start_over) begin
				phase      = PH_HEADER;
				hdr_idx    = 0;
				body_total = '0;
				meta_total = '0;
				bytes_left = '0;
			end
			case (phase)
				PH_HEADER: begin
					if (hdr_idx < 4) begin
						if (w.data_byte != HDR_MAGIC[31 - 8*hdr_idx -: 8]) begin
							phase           = PH_HALT;
							hdr_idx         = 0;
							r.kind          = KIND_ERROR;
							r.err_code      = ERR_MAGIC;
							r.last_of_frame = 1'b1;
							pending_words.push_back(r);
							return;
						end
					end else if (hdr_idx < 8) begin
						body_total = {body_total[23:0], w.data_byte};
					end else begin
						meta_total = {meta_total[23:0], w.data_byte};
					end
					hdr_idx++;
					if (hdr_idx == 12) begin
						hdr_idx         = 0;
						r.body_length   = body_total;
						r.meta_length   = meta_total;
						r.last_of_frame = 1'b1;
						// size checks: too big wins over metadata overrun
						if (body_total > max_body) begin
							phase      = PH_HALT;
							r.kind     = KIND_ERROR;
							r.err_code = ERR_TOO_BIG;
						end else if (meta_total > body_total) begin
							phase      = PH_HALT;
							r.kind     = KIND_ERROR;
							r.err_code = ERR_META_BODY;
						end else begin
							r.kind          = KIND_HEADER;
							r.last_of_frame = (body_total == 0);
							bytes_left      = body_total;
							phase           = (body_total == 0) ? PH_HEADER : PH_BODY;
						end
						pending_words.push_back(r);
					end
				end
				PH_BODY: begin
					pos             = body_total - bytes_left;
					r.kind          = (pos < meta_total) ? KIND_META : KIND_PAY;
					r.out_byte      = w.data_byte;
					r.last_of_frame = (bytes_left <= 1);
					if (bytes_left != 0)
						bytes_left--;
					if (bytes_left == 0) begin
						phase   = PH_HEADER;
						hdr_idx = 0;
					end
					pending_words.push_back(r);
				end
				default: ; // halted: byte dropped
			endcase
		endfunction

		function int field_bad(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		// compare one accepted result word against the oldest prediction
		function void check_word(rfd_out_t got);
			rfd_out_t want;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = pending_words[0];
			pending_words.delete(0);
			errors += field_bad("kind", want.kind, got.kind);
			errors += field_bad("out_byte", want.out_byte, got.out_byte);
			errors += field_bad("body_length", want.body_length, got.body_length);
			errors += field_bad("meta_length", want.meta_length, got.meta_length);
			errors += field_bad("err_code", want.err_code, got.err_code);
			errors += field_bad("last_of_frame", want.last_of_frame, got.last_of_frame);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	rfd_in_t     byte_word;
	logic        res_valid;
	logic        res_stall;
	rfd_out_t    res_word;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	deframe_scoreboard sb;
	bit          calm;          // no gaps and no new stalls while set
	int unsigned frame_bytes;
	int unsigned quiet_cycles;
	int unsigned stall_hold;

	rpc_frame_deframer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result checking
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_word(res_word);
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver stalls: mostly open, short bursts, an occasional long one
	always @(negedge clk) begin : stall_gen
		int r;
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (calm) begin
			res_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				res_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 8);
			end else if (r < 95) begin
				res_stall  <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else begin
				res_stall  <= 1'b1;
				stall_hold <= $urandom_range(10, 30);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	// one byte word on the byte channel, after a random gap
	task automatic send_byte(input logic [7:0] b, input logic so);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			byte_valid <= 1'b0;
			byte_word  <= rfd_in_t'(9'($urandom));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_word  <= rfd_in_t'{data_byte: b, start_over: so};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		sb.note_byte(rfd_in_t'{data_byte: b, start_over: so});
	endtask

	// drop valid, drain all predicted results, let the pipeline empty
	task automatic settle();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max(input logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.max_body = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// a frame with given sizes; bad_pos corrupts one magic byte (-1: none),
	// cut stops after that many bytes (-1: whole frame)
	task automatic send_frame(input logic [31:0] blen, input logic [31:0] mlen,
	                          input int bad_pos, input int cut);
		logic [7:0] hdr [12];
		int         n_body;
		int         total;
		logic       so;
		for (int i = 0; i < 4; i++) begin
			hdr[i] = HDR_MAGIC[31 - 8*i -: 8];
			if (i == bad_pos)
				hdr[i] = hdr[i] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < 4; i++) begin
			hdr[4 + i] = blen[31 - 8*i -: 8];
			hdr[8 + i] = mlen[31 - 8*i -: 8];
		end
		// no body goes out after a size error; huge bodies are cut short
		n_body = (blen > sb.max_body || mlen > blen) ? 0 : (blen > 64 ? 64 : int'(blen));
		total  = (bad_pos >= 0) ? bad_pos + 1 : 12 + n_body;
		if (cut >= 1 && cut < total)
			total = cut;
		so = sb.mid_frame() ? 1'b1 : ($urandom_range(0, 4) == 0);
		for (int i = 0; i < total; i++) begin
			send_byte((i < 12) ? hdr[i] : 8'($urandom), (i == 0) ? so : 1'b0);
			frame_bytes++;
		end
	endtask

	task automatic random_phase(input int unsigned target);
		int          r;
		logic [31:0] blen;
		logic [31:0] mlen;
		target = frame_bytes + target;
		while (frame_bytes < target) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				// well-formed frame, small body
				blen = $urandom_range(0, 10);
				mlen = $urandom_range(0, blen);
				send_frame(blen, mlen, -1, -1);
			end else if (r < 60) begin
				// bad magic, then bytes the halted block drops
				send_frame($urandom_range(0, 8), 0, $urandom_range(0, 3), -1);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
			end else if (r < 70) begin
				// full-range sizes: often a size error, else a long body cut short
				send_frame($urandom, $urandom, -1, -1);
			end else if (r < 80) begin
				// metadata larger than body
				blen = $urandom_range(0, 30);
				mlen = $urandom;
				if (mlen <= blen)
					mlen = blen + 1;
				send_frame(blen, mlen, -1, -1);
			end else if (r < 92) begin
				// frame abandoned in the header or the body
				blen = $urandom_range(1, 40);
				mlen = $urandom_range(0, blen);
				send_frame(blen, mlen, -1, $urandom_range(1, 11 + blen));
			end else begin
				// line noise
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		sb           = new();
		calm         = 1'b0;
		frame_bytes  = 0;
		quiet_cycles = 0;
		stall_hold   = 0;
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		byte_word    = '0;
		res_stall    = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: normal, empty, each error, halt, restarts
		send_frame(3, 1, -1, -1);
		send_frame(0, 0, -1, -1);
		send_frame(4, 2, 2, -1);
		send_byte(8'hFF, 1'b0);
		send_frame(32'hFFFF_FFFF, 0, -1, -1);
		send_frame(2, 32'hFFFF_FFFF, -1, -1);
		send_frame(5, 5, -1, 6);
		send_frame(5, 0, -1, 14);
		send_frame(1, 1, -1, -1);
		write_max(32'h0);
		send_frame(0, 0, -1, -1);
		send_frame(1, 0, -1, -1);

		// random phases over a spread of size limits
		frame_bytes = 0;
		write_max(32'hFFFF_FFFF);
		random_phase(50);
		write_max(32'h0);
		random_phase(50);
		calm = 1'b1;
		write_max(32'd8);
		random_phase(50);
		calm = 1'b0;
		write_max($urandom_range(1, 40));
		random_phase(50);
		write_max($urandom);
		random_phase(50);
		write_max(32'h0400_0000);
		random_phase(50);

		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* rpc_frame_deframer.f */
src/rfd_pkg.sv
src/rpc_frame_deframer.sv
src/rfd_checker.sv
test/tb_rpc_frame_deframer.sv
